// File: sv/request_queue_retry_timeout_unit_macros.svh
// Assertion macros for the request queue retry/timeout unit.
// Used by the checker; expects clk and rst in scope.
`ifndef REQUEST_QUEUE_RETRY_TIMEOUT_UNIT_MACROS_SVH
`define REQUEST_QUEUE_RETRY_TIMEOUT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RQRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RQRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rqrt_pkg.sv
// Shared types, codes and sizes for the request queue retry/timeout unit.
// No dependencies.
package rqrt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FUNC_W      = 2;
  localparam int KIND_W      = 2;
  localparam int ITEM_W      = 8;
  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 16;
  localparam int ATTEMPT_W   = 8;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SERVICE,
    FUNC_ENQUEUE,
    FUNC_RESPONSE,
    FUNC_CLEAR
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND,
    KIND_ANSWER,
    KIND_TIMEOUT,
    KIND_FULL
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_EMIT,
    ST_SCAN,
    ST_ANS_EMIT,
    ST_FULL_EMIT,
    ST_SEND_RD,
    ST_SEND_EMIT
  } state_t;

  localparam logic [CFG_ADDR_W-1:0] REG_RETRY_INTERVAL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ATTEMPTS   = 1'b1;

  localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RESET = 16'd500;
  localparam logic [ATTEMPT_W-1:0]  MAX_ATTEMPTS_RESET   = 8'd4;
  localparam logic [ATTEMPT_W-1:0]  ATTEMPT_MAX          = 8'hFF;

  typedef struct packed {
    logic we;
    idx_t waddr;
    id_t  wdata;
    idx_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic  push;
    kind_t kind;
    id_t   item;
    logic  last;
  } evt_t;

endpackage

// File: sv/rqrt_queue_mem.sv
// Pending-identifier queue storage: one write port, one registered read port.
// Depends on rqrt_pkg.
module rqrt_queue_mem (
  input  logic               clk,
  input  rqrt_pkg::mem_req_t req,
  output rqrt_pkg::id_t      rdata
);
  import rqrt_pkg::*;

  id_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: sv/rqrt_seq.sv
// Sequencer for the retry/timeout unit: scan and compaction of the queue,
// retry timing, attempt counting and event generation. Depends on rqrt_pkg.
module rqrt_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rqrt_pkg::FUNC_W-1:0]          func,
  input  logic [rqrt_pkg::ITEM_W-1:0]          item_id,
  input  logic [rqrt_pkg::TIME_W-1:0]          now_ms,
  input  logic [rqrt_pkg::INTERVAL_W-1:0]      retry_interval,
  input  logic [rqrt_pkg::ATTEMPT_W-1:0]       max_attempts,
  input  logic                                 out_free,
  output rqrt_pkg::mem_req_t                   mem_req,
  input  rqrt_pkg::id_t                        mem_rdata,
  output rqrt_pkg::evt_t                       evt
);
  import rqrt_pkg::*;

  state_t                state, state_next;
  func_t                 op, op_next;
  id_t                   id_q, id_q_next;
  logic [TIME_W-1:0]     now_q, now_q_next;
  cnt_t                  count, count_next;
  logic [TIME_W-1:0]     sent_time, sent_time_next;
  logic [ATTEMPT_W-1:0]  attempt, attempt_next;
  logic                  found, found_next;
  cnt_t                  rd_ptr, rd_ptr_next;
  logic                  p_vld, p_vld_next;
  idx_t                  p_idx, p_idx_next;

  logic [TIME_W-1:0]     elapsed;
  logic                  due;
  logic                  give_up;
  cnt_t                  cnt_after;

  assign elapsed   = now_ms - sent_time;
  assign due       = (count != '0) && (elapsed >= TIME_W'(retry_interval));
  assign give_up   = attempt >= max_attempts;
  assign cnt_after = count - cnt_t'(found);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sent_time <= '0;
      attempt   <= '0;
      found     <= 1'b0;
      rd_ptr    <= '0;
      p_vld     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sent_time <= sent_time_next;
      attempt   <= attempt_next;
      found     <= found_next;
      rd_ptr    <= rd_ptr_next;
      p_vld     <= p_vld_next;
    end
    op    <= op_next;
    id_q  <= id_q_next;
    now_q <= now_q_next;
    p_idx <= p_idx_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    id_q_next      = id_q;
    now_q_next     = now_q;
    count_next     = count;
    sent_time_next = sent_time;
    attempt_next   = attempt;
    found_next     = found;
    rd_ptr_next    = rd_ptr;
    p_vld_next     = p_vld;
    p_idx_next     = p_idx;
    mem_req        = '0;
    evt            = '0;
    in_ready       = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_next    = func_t'(func);
          id_q_next  = id_t'(item_id);
          now_q_next = now_ms;
          unique case (func_t'(func))
            FUNC_CLEAR: begin
              count_next     = '0;
              sent_time_next = '0;
              attempt_next   = '0;
            end
            FUNC_SERVICE: begin
              if (due) begin
                state_next = give_up ? ST_FRONT_RD : ST_SEND_RD;
              end
            end
            FUNC_ENQUEUE, FUNC_RESPONSE: begin
              rd_ptr_next = '0;
              p_vld_next  = 1'b0;
              found_next  = 1'b0;
              state_next  = ST_SCAN;
            end
          endcase
        end
      end
      ST_FRONT_RD: begin
        state_next = ST_FRONT_EMIT;
      end
      ST_FRONT_EMIT: begin
        if (out_free) begin
          evt.push    = 1'b1;
          evt.kind    = KIND_TIMEOUT;
          evt.item    = mem_rdata;
          evt.last    = (count == cnt_t'(1));
          // drop the front: compact from entry one onward
          rd_ptr_next = cnt_t'(1);
          p_vld_next  = 1'b0;
          found_next  = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_ptr < count) begin
          mem_req.raddr = rd_ptr[IDX_W-1:0];
          rd_ptr_next   = cnt_t'(rd_ptr + 1'b1);
          p_vld_next    = 1'b1;
          p_idx_next    = rd_ptr[IDX_W-1:0];
        end else begin
          p_vld_next = 1'b0;
        end
        if (p_vld) begin
          if (found) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_t'(p_idx - 1'b1);
            mem_req.wdata = mem_rdata;
          end else if (mem_rdata == id_q) begin
            found_next = 1'b1;
          end
        end else if (rd_ptr >= count) begin
          unique case (op)
            FUNC_SERVICE: begin
              count_next   = cnt_after;
              attempt_next = '0;
              state_next   = (cnt_after != '0) ? ST_SEND_RD : ST_IDLE;
            end
            FUNC_ENQUEUE: begin
              count_next = cnt_after;
              if (cnt_after >= cnt_t'(QUEUE_DEPTH)) begin
                state_next = ST_FULL_EMIT;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_after[IDX_W-1:0];
                mem_req.wdata = id_q;
                count_next    = cnt_t'(cnt_after + 1'b1);
                if (cnt_after == '0) begin
                  attempt_next = '0;
                  state_next   = ST_SEND_RD;
                end else begin
                  state_next = ST_IDLE;
                end
              end
            end
            FUNC_RESPONSE: begin
              if (found) begin
                count_next   = cnt_after;
                attempt_next = '0;
                state_next   = ST_ANS_EMIT;
              end else begin
                state_next = ST_IDLE;
              end
            end
            FUNC_CLEAR: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_ANS_EMIT: begin
        if (out_free) begin
          evt.push   = 1'b1;
          evt.kind   = KIND_ANSWER;
          evt.item   = id_q;
          evt.last   = (count == '0);
          state_next = (count != '0) ? ST_SEND_RD : ST_IDLE;
        end
      end
      ST_FULL_EMIT: begin
        if (out_free) begin
          evt.push   = 1'b1;
          evt.kind   = KIND_FULL;
          evt.item   = id_q;
          evt.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SEND_RD: begin
        state_next = ST_SEND_EMIT;
      end
      ST_SEND_EMIT: begin
        if (out_free) begin
          evt.push       = 1'b1;
          evt.kind       = KIND_SEND;
          evt.item       = mem_rdata;
          evt.last       = 1'b1;
          sent_time_next = now_q;
          if (attempt != ATTEMPT_MAX) begin
            attempt_next = attempt + 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
    endcase
  end

endmodule

// File: sv/request_queue_retry_timeout_unit.sv
// Request queue with retry and timeout: one transaction in, up to two events out.
// A resend reads the front entry and emits it. An enqueue or response scans the queue,
// removes a matching entry and may then send; a give-up emits a timeout first.
// The scan walks one entry per cycle through the store's single read port.
// Registered output: stalls hold the FSM; input reopens while the last event waits.
// Synchronous reset empties the queue and loads interval 500 and max attempts 4.
module request_queue_retry_timeout_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rqrt_pkg::FUNC_W-1:0]       func,
  input  logic [rqrt_pkg::ITEM_W-1:0]       item_id,
  input  logic [rqrt_pkg::TIME_W-1:0]       now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rqrt_pkg::KIND_W-1:0]       event_kind,
  output logic [rqrt_pkg::ITEM_W-1:0]       event_item,
  output logic                              last_event,
  input  logic                              cfg_we,
  input  logic [rqrt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rqrt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rqrt_pkg::*;

  logic [INTERVAL_W-1:0] retry_interval_ms;
  logic [ATTEMPT_W-1:0]  max_attempts;
  mem_req_t              mem_req;
  id_t                   mem_rdata;
  evt_t                  evt;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval_ms <= RETRY_INTERVAL_RESET;
      max_attempts      <= MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_RETRY_INTERVAL) begin
        retry_interval_ms <= cfg_wdata[INTERVAL_W-1:0];
      end
      if (cfg_addr == REG_MAX_ATTEMPTS) begin
        max_attempts <= cfg_wdata[ATTEMPT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (evt.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (evt.push) begin
      event_kind <= evt.kind;
      event_item <= ITEM_W'(evt.item);
      last_event <= evt.last;
    end
  end

  rqrt_queue_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rqrt_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .item_id        (item_id),
    .now_ms         (now_ms),
    .retry_interval (retry_interval_ms),
    .max_attempts   (max_attempts),
    .out_free       (out_free),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .evt            (evt)
  );

endmodule

// File: sv/rqrt_checker.sv
// Port-level checks for the request queue retry/timeout unit, with its bind.
// Depends on rqrt_pkg and request_queue_retry_timeout_unit_macros.svh.
`include "request_queue_retry_timeout_unit_macros.svh"

module rqrt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [rqrt_pkg::FUNC_W-1:0]  func,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rqrt_pkg::KIND_W-1:0]  event_kind,
  input logic [rqrt_pkg::ITEM_W-1:0]  event_item,
  input logic                         last_event
);
  import rqrt_pkg::*;

  `RQRT_ASSERT_NEXT(a_clear_ready, in_valid && in_ready && (func == FUNC_CLEAR), in_ready, "not ready after clear")
  `RQRT_ASSERT_SAME(a_first_busy, out_valid && !last_event, !in_ready, "ready before last event")
  `RQRT_ASSERT_SAME(a_single_last, out_valid && (event_kind == KIND_SEND || event_kind == KIND_FULL), last_event, "send or drop not last")
  `RQRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(event_item) && $stable(last_event), "stalled event changed")

endmodule

bind request_queue_retry_timeout_unit rqrt_checker u_rqrt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .func       (func),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_kind (event_kind),
  .event_item (event_item),
  .last_event (last_event)
);
